/* hw/rtl/icr_pkg.sv */
// Shared types and constants for the incidence covariance row block.
package icr_pkg;
  localparam int MaxTimes = 64;
  localparam int IdxW = $clog2(MaxTimes);
  localparam int CntW = IdxW + 1;
  localparam int ValW = 48;
  localparam int CifW = 17;

  localparam logic signed [ValW-1:0] SatMax = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] SatMin = {1'b1, {(ValW-1){1'b0}}};

  localparam logic [1:0] KindCause = 2'd1;
  localparam logic [1:0] KindCompeting = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_MUL1, ST_MUL2, ST_MUL3, ST_ACC, ST_ROW_RD, ST_ROW_M1,
    ST_ROW_M2, ST_ROW_OUT
  } icr_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic mul1;
    logic mul2;
    logic mul3;
    logic acc;
    logic row_start;
    logic row_rd;
    logic row_m1;
    logic row_m2;
    logic out_load;
  } icr_cmd_t;

  typedef struct packed {
    logic full;
    logic contrib;
    logic div_done;
    logic row_last;
  } icr_sts_t;

  function automatic logic signed [ValW-1:0] sat48(input logic signed [ValW+1:0] v);
    if (v > $signed({2'b00, SatMax})) return SatMax;
    if (v < $signed({2'b11, SatMin})) return SatMin;
    return v[ValW-1:0];
  endfunction
endpackage

/* hw/rtl/icr_in_if.sv */
// Input channel interface.
interface icr_in_if;
  logic valid;
  logic ready;
  logic first_of_set;
  logic [1:0] event_kind;
  logic [7:0] group_id;
  logic [16:0] first_cif;
  logic [16:0] other_cif;
  logic [15:0] at_risk;
  modport source(output valid, first_of_set, event_kind, group_id, first_cif, other_cif,
                 at_risk, input ready);
  modport sink(input valid, first_of_set, event_kind, group_id, first_cif, other_cif,
               at_risk, output ready);
endinterface

/* hw/rtl/icr_out_if.sv */
// Result channel interface.
interface icr_out_if;
  logic valid;
  logic ready;
  logic [5:0] row_index;
  logic [5:0] col_index;
  logic signed [47:0] cov_value;
  logic last_of_row;
  modport source(output valid, row_index, col_index, cov_value, last_of_row, input ready);
  modport sink(input valid, row_index, col_index, cov_value, last_of_row, output ready);
endinterface

/* hw/rtl/icr_ctrl.sv */
// Controller state machine sequencing update, store and row emission.
module icr_ctrl
  import icr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       out_valid,
  input  logic       out_ready,
  input  icr_sts_t   sts,
  output icr_cmd_t   cmd
);
  icr_state_t state_r, state_nxt;
  logic out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_DIV;
      ST_DIV: begin
        if (sts.full) state_nxt = ST_IDLE;
        else if (!sts.contrib) state_nxt = ST_ACC;
        else if (sts.div_done) state_nxt = ST_MUL1;
      end
      ST_MUL1:    state_nxt = ST_MUL2;
      ST_MUL2:    state_nxt = ST_MUL3;
      ST_MUL3:    state_nxt = ST_ACC;
      ST_ACC:     state_nxt = ST_ROW_RD;
      ST_ROW_RD:  state_nxt = ST_ROW_M1;
      ST_ROW_M1:  state_nxt = ST_ROW_M2;
      ST_ROW_M2:  state_nxt = ST_ROW_OUT;
      ST_ROW_OUT: begin
        if (out_free) state_nxt = sts.row_last ? ST_IDLE : ST_ROW_RD;
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cmd.div_start = in_valid;
      end
      ST_DIV:     cmd = '0;
      ST_MUL1:    cmd.mul1 = 1'b1;
      ST_MUL2:    cmd.mul2 = 1'b1;
      ST_MUL3:    cmd.mul3 = 1'b1;
      ST_ACC: begin
        cmd.acc = 1'b1;
        cmd.row_start = 1'b1;
      end
      ST_ROW_RD:  cmd.row_rd = 1'b1;
      ST_ROW_M1:  cmd.row_m1 = 1'b1;
      ST_ROW_M2:  cmd.row_m2 = 1'b1;
      ST_ROW_OUT: cmd.out_load = out_free;
      default:    cmd = '0;
    endcase
  end
endmodule

/* hw/rtl/icr_datapath.sv */
// Datapath: weight divider, sum update, history tables and row arithmetic.
module icr_datapath
  import icr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  icr_cmd_t    cmd,
  output icr_sts_t    sts,
  input  logic [7:0]  cfg_target,
  input  logic        in_first_of_set,
  input  logic [1:0]  in_event_kind,
  input  logic [7:0]  in_group_id,
  input  logic [16:0] in_first_cif,
  input  logic [16:0] in_other_cif,
  input  logic [15:0] in_at_risk,
  input  logic        out_ready,
  output logic        out_valid,
  output logic [5:0]  out_row_index,
  output logic [5:0]  out_col_index,
  output logic signed [47:0] out_cov_value,
  output logic        out_last_of_row
);
  // Item registers.
  logic [1:0]  kind_r;
  logic        grp_ok_r;
  logic [16:0] f1_r, f2_r;
  logic [31:0] yy_r;
  logic        clear_r;
  logic [CntW-1:0] count_r, count_nxt;
  logic signed [ValW-1:0] sum_ab_r, sum_c_r, sum_de_r;

  // Restoring divider for 2^40 / y^2, one quotient bit a cycle.
  logic [40:0] div_q_r;
  logic [32:0] div_rem_r;
  logic [5:0]  div_cnt_r;
  logic        div_busy_r;
  logic [32:0] div_trial;

  // Update products.
  logic [17:0] mag_r;     // |u| or F1
  logic        neg_r;
  logic [18:0] sq_r;
  logic [66:0] sq_prod_r, lin_prod_r;

  // Tables.
  logic [16:0] tab_cif [MaxTimes];
  logic signed [ValW-1:0] tab_ab [MaxTimes];
  logic signed [ValW-1:0] tab_c [MaxTimes];
  logic signed [ValW-1:0] tab_de [MaxTimes];

  logic [IdxW-1:0] t_r, j_r;
  logic [16:0] fj_r;
  logic signed [ValW-1:0] ab_j_r, c_j_r, de_j_r;
  logic [17:0] p_r;
  logic [17:0] fs_r;
  logic signed [ValW+1:0] term_c_r, term_de_r;
  logic signed [ValW-1:0] ab_d_r;

  logic contrib;
  logic [CntW-1:0] eff_count;

  assign eff_count = clear_r ? '0 : count_r;
  assign contrib = (yy_r != '0) && grp_ok_r && (kind_r == KindCause || kind_r == KindCompeting);

  always_comb begin
    sts.full = eff_count >= CntW'(MaxTimes);
    sts.contrib = contrib;
    sts.div_done = div_busy_r && (div_cnt_r == '0);
    sts.row_last = (j_r == t_r);
  end

  assign div_trial = {div_rem_r[31:0], div_q_r[40]} - {1'b0, yy_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r <= in_event_kind;
      grp_ok_r <= (in_group_id == cfg_target);
      f1_r <= in_first_cif;
      f2_r <= in_other_cif;
      yy_r <= in_at_risk * in_at_risk;
      clear_r <= in_first_of_set;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
    end else if (cmd.div_start) begin
      div_busy_r <= 1'b1;
      div_cnt_r <= 6'd41;
      div_q_r <= {1'b1, 40'd0};
      div_rem_r <= '0;
    end else if (div_busy_r && div_cnt_r != '0) begin
      div_cnt_r <= div_cnt_r - 6'd1;
      if (!div_trial[32]) begin
        div_rem_r <= div_trial;
        div_q_r <= {div_q_r[39:0], 1'b1};
      end else begin
        div_rem_r <= {div_rem_r[31:0], div_q_r[40]};
        div_q_r <= {div_q_r[39:0], 1'b0};
      end
    end else if (cmd.acc) begin
      div_busy_r <= 1'b0;
    end
  end

  // Weight below 2^41 fits; products kept exact then shifted.
  always_ff @(posedge clk) begin
    logic signed [18:0] u;
    u = 19'sd65536 - $signed({2'b00, f2_r});
    if (cmd.mul1) begin
      if (kind_r == KindCause) begin
        mag_r <= u[18] ? 18'(-u) : 18'(u);
        neg_r <= u[18];
      end else begin
        mag_r <= {1'b0, f1_r};
        neg_r <= 1'b0;
      end
    end
    if (cmd.mul2) sq_r <= 19'((36'(mag_r) * 36'(mag_r)) >> 16);
    if (cmd.mul3) begin
      sq_prod_r <= (67'(sq_r) * 67'(div_q_r)) >> 16;
      lin_prod_r <= (67'(mag_r) * 67'(div_q_r)) >> 16;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (cmd.acc) count_nxt = eff_count + 1'b1;
  end

  always_ff @(posedge clk) begin
    logic signed [ValW+1:0] ab_b, c_b, de_b, lin;
    ab_b = clear_r ? '0 : {{2{sum_ab_r[ValW-1]}}, sum_ab_r};
    c_b = clear_r ? '0 : {{2{sum_c_r[ValW-1]}}, sum_c_r};
    de_b = clear_r ? '0 : {{2{sum_de_r[ValW-1]}}, sum_de_r};
    lin = $signed({1'b0, lin_prod_r[ValW:0]});
    if (!rst_n) begin
      count_r <= '0;
      sum_ab_r <= '0;
      sum_c_r <= '0;
      sum_de_r <= '0;
    end else begin
      count_r <= count_nxt;
      if (cmd.acc) begin
        if (contrib) begin
          sum_ab_r <= sat48(ab_b + $signed({1'b0, sq_prod_r[ValW:0]}));
          sum_c_r <= sat48(c_b + $signed({9'd0, div_q_r}));
          sum_de_r <= sat48(neg_r ? de_b - lin : de_b + lin);
        end else begin
          sum_ab_r <= ab_b[ValW-1:0];
          sum_c_r <= c_b[ValW-1:0];
          sum_de_r <= de_b[ValW-1:0];
        end
      end
    end
  end

  // Table write at the row start, with the updated sums.
  logic wr_pending_r;
  always_ff @(posedge clk) begin
    if (!rst_n) wr_pending_r <= 1'b0;
    else wr_pending_r <= cmd.acc;
    if (cmd.acc) t_r <= eff_count[IdxW-1:0];
    if (wr_pending_r) begin
      tab_cif[t_r] <= f1_r;
      tab_ab[t_r] <= sum_ab_r;
      tab_c[t_r] <= sum_c_r;
      tab_de[t_r] <= sum_de_r;
    end
  end

  // The first read of a row can meet the entry that is being written.
  logic fwd;
  assign fwd = wr_pending_r && (j_r == t_r);

  // Row entries: read, multiply, combine.
  always_ff @(posedge clk) begin
    if (cmd.row_start) j_r <= '0;
    else if (cmd.out_load) j_r <= j_r + 1'b1;
    if (cmd.row_rd) begin
      fj_r <= fwd ? f1_r : tab_cif[j_r];
      ab_j_r <= fwd ? sum_ab_r : tab_ab[j_r];
      c_j_r <= fwd ? sum_c_r : tab_c[j_r];
      de_j_r <= fwd ? sum_de_r : tab_de[j_r];
    end
  end

  function automatic logic signed [ValW+1:0] smul16(input logic [17:0] a,
                                                    input logic signed [ValW-1:0] b);
    logic [ValW-1:0] mb;
    logic [65:0] r;
    mb = b[ValW-1] ? ValW'(-b) : ValW'(b);
    r = (66'(a) * 66'(mb)) >> 16;
    return b[ValW-1] ? -$signed({1'b0, r[ValW:0]}) : $signed({1'b0, r[ValW:0]});
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.row_m1) begin
      p_r <= 18'((34'(f1_r) * 34'(fj_r)) >> 16);
      fs_r <= 18'(f1_r) + 18'(fj_r);
    end
    if (cmd.row_m2) begin
      term_c_r <= smul16(p_r, c_j_r);
      term_de_r <= smul16(fs_r, de_j_r);
      ab_d_r <= ab_j_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [ValW+3:0] v;
    v = 52'(ab_d_r) + 52'(term_c_r) - 52'(term_de_r);
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
      out_row_index <= 6'(t_r);
      out_col_index <= 6'(j_r);
      out_last_of_row <= (j_r == t_r);
      if (v > 52'(SatMax)) out_cov_value <= SatMax;
      else if (v < 52'(SatMin)) out_cov_value <= SatMin;
      else out_cov_value <= v[ValW-1:0];
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
endmodule

/* hw/rtl/incidence_covariance_rows.sv */
// Covariance row generator: one input transaction yields one lower-triangular row
// unless its set already fills the table. Steps: divide, MUL1..MUL3, update, then
// per entry read, ROW_M1, ROW_M2, output; items without weight go straight to update.
// A new item is taken only when idle, once the last entry of the previous row is loaded.
// Synchronous active-low reset clears sums, time count and target group.
// The history tables are not cleared; only entries of the current set are read.
module incidence_covariance_rows
  import icr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  icr_in_if.sink     in_ch,
  icr_out_if.source  out_ch
);
  logic [7:0] target_r;
  icr_cmd_t cmd;
  icr_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) target_r <= '0;
    else if (cfg_we) target_r <= cfg_wdata;
  end

  icr_ctrl u_ctrl (
    .clk, .rst_n,
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .sts, .cmd
  );

  icr_datapath u_dp (
    .clk, .rst_n, .cmd, .sts,
    .cfg_target(target_r),
    .in_first_of_set(in_ch.first_of_set),
    .in_event_kind(in_ch.event_kind),
    .in_group_id(in_ch.group_id),
    .in_first_cif(in_ch.first_cif),
    .in_other_cif(in_ch.other_cif),
    .in_at_risk(in_ch.at_risk),
    .out_ready(out_ch.ready),
    .out_valid(out_ch.valid),
    .out_row_index(out_ch.row_index),
    .out_col_index(out_ch.col_index),
    .out_cov_value(out_ch.cov_value),
    .out_last_of_row(out_ch.last_of_row)
  );
endmodule

/* bench/incidence_covariance_rows_tb.sv */
// Self-checking testbench for the incidence covariance row generator.
module incidence_covariance_rows_tb
  import icr_pkg::*;
();

  localparam logic [1:0] KindCensored = 2'd0;
  localparam logic [1:0] KindUnused = 2'd3;
  localparam int QuietLimit = 5000;
  localparam int SettleCycles = 300;
  localparam int LongHold = 800;

  typedef struct {
    bit first;
    bit [1:0] kind;
    bit [7:0] grp;
    bit [16:0] f1;
    bit [16:0] f2;
    bit [15:0] y;
  } event_item_t;

  typedef struct {
    bit [5:0] row;
    bit [5:0] col;
    logic signed [47:0] cov;
    bit last;
  } cov_entry_t;

  class cov_scoreboard;
    bit [7:0] target;
    longint acc_ab, acc_c, acc_de;
    int unsigned n_times;
    bit [16:0] cif_hist[MaxTimes];
    longint ab_hist[MaxTimes];
    longint c_hist[MaxTimes];
    longint de_hist[MaxTimes];
    cov_entry_t pending_q[$];
    int errors;

    function new();
      target = 0;
      acc_ab = 0;
      acc_c = 0;
      acc_de = 0;
      n_times = 0;
      errors = 0;
    endfunction

    function longint clamp48(longint v);
      if (v > 64'sd140737488355327) return 64'sd140737488355327;
      if (v < -64'sd140737488355328) return -64'sd140737488355328;
      return v;
    endfunction

    // Unsigned Q48.16 factor times a signed Q7.40 value, truncated toward zero.
    function longint scale_q16(bit [63:0] a, longint b);
      bit [127:0] mag;
      bit [127:0] prod;
      mag = (b < 0) ? 128'(-b) : 128'(b);
      prod = (128'(a) * mag) >> 16;
      return (b < 0) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
    endfunction

    function bit is_full(event_item_t it);
      return !it.first && n_times >= MaxTimes;
    endfunction

    function void note_item(event_item_t it);
      longint w, sq_term, lin_term, u, v;
      bit [63:0] mu, sq, p;
      int t;
      cov_entry_t e;
      if (it.first) begin
        acc_ab = 0;
        acc_c = 0;
        acc_de = 0;
        n_times = 0;
      end
      if (n_times >= MaxTimes) return;
      if (it.y != 0 && it.grp == target && (it.kind == KindCause || it.kind == KindCompeting))
      begin
        w = (longint'(1) << 40) / (longint'(it.y) * longint'(it.y));
        if (it.kind == KindCause) begin
          u = 65536 - longint'(it.f2);
          mu = (u < 0) ? -u : u;
          sq = (mu * mu) >> 16;
          sq_term = scale_q16(sq, w);
          lin_term = scale_q16(mu, w);
          if (u < 0) lin_term = -lin_term;
        end else begin
          sq = (64'(it.f1) * 64'(it.f1)) >> 16;
          sq_term = scale_q16(sq, w);
          lin_term = scale_q16(64'(it.f1), w);
        end
        acc_ab = clamp48(acc_ab + sq_term);
        acc_c = clamp48(acc_c + w);
        acc_de = clamp48(acc_de + lin_term);
      end
      t = n_times;
      cif_hist[t] = it.f1;
      ab_hist[t] = acc_ab;
      c_hist[t] = acc_c;
      de_hist[t] = acc_de;
      for (int j = 0; j <= t; j++) begin
        p = (64'(it.f1) * 64'(cif_hist[j])) >> 16;
        v = ab_hist[j] + scale_q16(p, c_hist[j])
            - scale_q16(64'(it.f1) + 64'(cif_hist[j]), de_hist[j]);
        v = clamp48(v);
        e.row = 6'(t);
        e.col = 6'(j);
        e.cov = v[47:0];
        e.last = (j == t);
        pending_q.push_back(e);
      end
      n_times++;
    endfunction

    function void check_entry(cov_entry_t got);
      cov_entry_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result row=%0d col=%0d", got.row, got.col);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (got.row != want.row) begin
        $error("row_index: expected %0d, actual %0d", want.row, got.row);
        errors++;
      end
      if (got.col != want.col) begin
        $error("col_index: expected %0d, actual %0d", want.col, got.col);
        errors++;
      end
      if (got.cov !== want.cov) begin
        $error("cov_value: expected %0d, actual %0d", want.cov, got.cov);
        errors++;
      end
      if (got.last != want.last) begin
        $error("last_of_row: expected %0d, actual %0d", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [7:0] cfg_wdata = 0;

  icr_in_if in_ch();
  icr_out_if out_ch();

  incidence_covariance_rows i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #4 clk = ~clk;

  cov_scoreboard sb = new();
  int burst_left = 0;
  int quiet_cycles = 0;
  bit hold_req = 0;
  int accepted_items = 0;

  initial begin
    in_ch.valid = 0;
    in_ch.first_of_set = 0;
    in_ch.event_kind = 0;
    in_ch.group_id = 0;
    in_ch.first_cif = 0;
    in_ch.other_cif = 0;
    in_ch.at_risk = 0;
    out_ch.ready = 0;
  end

  // Receiver: random stall pattern, with an occasional long hold-off on request.
  always begin
    int hold_cnt;
    int mode;
    hold_cnt = 0;
    mode = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 0;
        hold_cnt = LongHold;
      end
      if ($urandom_range(0, 63) == 0) mode = $urandom_range(0, 3);
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_ch.ready = 0;
      end else begin
        case (mode)
          0: out_ch.ready = 1;
          1: out_ch.ready = ($urandom_range(0, 3) != 0);
          2: out_ch.ready = 1'($urandom_range(0, 1));
          default: out_ch.ready = ($urandom_range(0, 4) == 0);
        endcase
      end
    end
  end

  // Result monitor and watchdog.
  always @(posedge clk) begin
    cov_entry_t got;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        got.row = out_ch.row_index;
        got.col = out_ch.col_index;
        got.cov = out_ch.cov_value;
        got.last = out_ch.last_of_row;
        sb.check_entry(got);
      end
      if ((out_ch.valid && out_ch.ready) || (in_ch.valid && in_ch.ready) || cfg_we) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QuietLimit) begin
          $display("** incidence_covariance_rows: FAILED **");
          $finish;
        end
      end
    end
  end

  task automatic send_item(event_item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      repeat (gap) begin
        @(negedge clk);
        in_ch.valid = 0;
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    @(negedge clk);
    in_ch.valid = 1;
    in_ch.first_of_set = it.first;
    in_ch.event_kind = it.kind;
    in_ch.group_id = it.grp;
    in_ch.first_cif = it.f1;
    in_ch.other_cif = it.f2;
    in_ch.at_risk = it.y;
    do @(posedge clk); while (!in_ch.ready);
    if (!sb.is_full(it)) accepted_items++;
    sb.note_item(it);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_ch.valid = 0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_target(bit [7:0] value);
    @(negedge clk);
    cfg_we = 1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 0;
    sb.target = value;
  endtask

  function automatic bit [16:0] pick_cif();
    case ($urandom_range(0, 9))
      0: return 17'd0;
      1: return 17'd65536;
      2: return 17'($urandom_range(65537, 131071));
      default: return 17'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic event_item_t make_item(bit first, bit [7:0] tgt);
    event_item_t it;
    it.first = first;
    it.kind = ($urandom_range(0, 4) == 0) ? 2'($urandom_range(0, 3))
                                          : 2'($urandom_range(1, 2));
    it.grp = ($urandom_range(0, 9) < 7) ? tgt : 8'($urandom_range(0, 255));
    it.f1 = pick_cif();
    it.f2 = pick_cif();
    case ($urandom_range(0, 7))
      0: it.y = 0;
      1: it.y = 1;
      2: it.y = 16'($urandom_range(0, 65535));
      default: it.y = 16'($urandom_range(1, 30));
    endcase
    return it;
  endfunction

  function automatic event_item_t mk(bit first, bit [1:0] kind, bit [7:0] grp,
                                     bit [16:0] f1, bit [16:0] f2, bit [15:0] y);
    event_item_t it;
    it.first = first;
    it.kind = kind;
    it.grp = grp;
    it.f1 = f1;
    it.f2 = f2;
    it.y = y;
    return it;
  endfunction

  initial begin
    bit [7:0] targets[4];
    event_item_t it;
    int set_len;
    targets[0] = 8'h00;
    targets[1] = 8'hFF;
    targets[2] = 8'($urandom_range(1, 254));
    targets[3] = 8'h01;

    repeat (5) @(negedge clk);
    rst_n = 1;

    // Directed part: field extremes, every kind, and the special cases.
    write_target(8'h00);
    send_item(mk(1, KindCause, 8'h00, 17'd0, 17'd0, 16'd1));
    send_item(mk(0, KindCompeting, 8'h00, 17'd65536, 17'd0, 16'd1));
    send_item(mk(0, KindCensored, 8'h00, 17'd30000, 17'd20000, 16'd5));
    send_item(mk(0, KindUnused, 8'h00, 17'd40000, 17'd1000, 16'd3));
    send_item(mk(0, KindCause, 8'h07, 17'd12345, 17'd5432, 16'd2));
    send_item(mk(0, KindCause, 8'h00, 17'd100, 17'd200, 16'd0));
    send_item(mk(0, KindCause, 8'h00, 17'd50000, 17'd131071, 16'd1));
    send_item(mk(0, KindCompeting, 8'h00, 17'd131071, 17'd131071, 16'd65535));
    send_item(mk(0, KindCause, 8'h00, 17'd131071, 17'd65536, 16'd2));
    send_item(mk(1, KindCompeting, 8'h00, 17'd70000, 17'd0, 16'd1));
    send_item(mk(0, KindCompeting, 8'h00, 17'd131071, 17'd0, 16'd1));
    send_item(mk(0, KindCause, 8'hFF, 17'd1, 17'd1, 16'd65535));
    send_item(mk(0, KindCause, 8'h00, 17'd65535, 17'd65535, 16'd256));
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      write_target(targets[ph]);
      if (ph == 1) hold_req = 1;
      if (ph == 3) begin
        // One set runs past the table end, with weights large enough to saturate.
        for (int k = 0; k < MaxTimes + 3; k++) begin
          it = mk(k == 0, KindCompeting, targets[ph], 17'($urandom_range(100000, 131071)),
                  17'($urandom_range(0, 65536)), 16'($urandom_range(1, 2)));
          send_item(it);
        end
      end
      while (accepted_items < 13 + 120 * (ph + 1)) begin
        set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 10);
        for (int k = 0; k < set_len; k++) send_item(make_item(k == 0, targets[ph]));
      end
      drain_results();
    end

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("** incidence_covariance_rows: PASSED **");
    end else begin
      $display("** incidence_covariance_rows: FAILED **");
    end
    $finish;
  end
endmodule
